@@ sv/fmtc_pkg.sv @@
// Shared types, constants and register codes of the Fourier mesh table correction block.
`timescale 1ns / 1ps
`default_nettype none
package fmtc_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned MESH_MAX_DEF    = 1024;
  localparam int unsigned FIFO_DEPTH      = 4;

  localparam int unsigned COORD_W  = 10;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned MESH_W   = 13;
  localparam int unsigned MODE_W   = 14;
  localparam int unsigned M2_W     = 2 * MODE_W;
  localparam int unsigned MANT_W   = 31;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned EXP_W    = 5;
  localparam int unsigned LOG_W    = EXP_W + FRAC_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [33:0] ONE_Q24 = 34'd16777216;

  localparam logic [10:0] MESH_RESET  = 11'd256;
  localparam logic [23:0] SCALE_RESET = 24'd65536;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_CELL = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MESH_SIZE     = 3'd0,
    CFG_STEP_SCALE    = 3'd1,
    CFG_STEP_OFFSET   = 3'd2,
    CFG_ROW_BLEND     = 3'd3,
    CFG_DENSITY_RATIO = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [MESH_W-1:0]       mesh_n;
    logic [23:0]             scale;
    logic signed [31:0]      offset;
    logic [16:0]             blend;
    logic [23:0]             density;
  } cfg_t;

  typedef struct packed {
    op_e                     op;
    logic [COORD_W-1:0]      ti;
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    logic [M2_W-1:0]         m2;
    logic signed [VAL_W-1:0] re;
    logic signed [VAL_W-1:0] im;
  } entry_t;

  typedef struct packed {
    op_e                     op;
    logic                    dc;
    logic [COORD_W-1:0]      ti;
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    logic signed [VAL_W-1:0] re;
    logic signed [VAL_W-1:0] im;
  } side_t;

endpackage
`default_nettype wire

@@ sv/fmtc_in_if.sv @@
// Input channel: table loads and mesh cells.
`timescale 1ns / 1ps
`default_nettype none
interface fmtc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [9:0]  table_index;
  logic signed [31:0] lower_value;
  logic signed [31:0] upper_value;
  logic [9:0]  x_coord;
  logic [9:0]  y_coord;
  logic [9:0]  z_coord;
  logic signed [31:0] real_part;
  logic signed [31:0] imag_part;

  modport source (
    output valid, operation, table_index, lower_value, upper_value,
           x_coord, y_coord, z_coord, real_part, imag_part,
    input  ready
  );
  modport sink (
    input  valid, operation, table_index, lower_value, upper_value,
           x_coord, y_coord, z_coord, real_part, imag_part,
    output ready
  );
endinterface
`default_nettype wire

@@ sv/fmtc_out_if.sv @@
// Output channel: corrected cell values.
`timescale 1ns / 1ps
`default_nettype none
interface fmtc_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] real_out;
  logic signed [31:0] imag_out;
  logic        range_flag;

  modport source (
    output valid, real_out, imag_out, range_flag,
    input  ready
  );
  modport sink (
    input  valid, real_out, imag_out, range_flag,
    output ready
  );
endinterface
`default_nettype wire

@@ sv/fmtc_ram.sv @@
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module fmtc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0]      rdata_a_o,
  output logic [WIDTH-1:0]      rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule
`default_nettype wire

@@ sv/fmtc_fifo.sv @@
// Short queue between the classifying front and the arithmetic back.
`timescale 1ns / 1ps
`default_nettype none
module fmtc_fifo #(
  parameter int unsigned DEPTH = fmtc_pkg::FIFO_DEPTH,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire fmtc_pkg::entry_t data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output fmtc_pkg::entry_t     data_o,
  output logic                 empty_o
);

  fmtc_pkg::entry_t mem_q [DEPTH];
  logic [AW-1:0] wptr_q, wptr_d;
  logic [AW-1:0] rptr_q, rptr_d;
  logic [CW-1:0] count_q, count_d;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH)) else $error("queue count out of bound");
  a_count_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not advance");

endmodule
`default_nettype wire

@@ sv/fmtc_front.sv @@
// Front: accepts items, folds coordinates into modes and forms the squared magnitude.
`timescale 1ns / 1ps
`default_nettype none
module fmtc_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire fmtc_pkg::cfg_t   cfg_i,
  fmtc_in_if.sink               in_i,
  output logic                  push_o,
  output fmtc_pkg::entry_t      data_o,
  input  wire logic             full_i
);

  logic                    f_v_q;
  logic                    f_op_q;
  logic [9:0]              f_ti_q;
  logic signed [31:0]      f_lo_q;
  logic signed [31:0]      f_hi_q;
  logic [9:0]              f_x_q;
  logic [9:0]              f_y_q;
  logic [9:0]              f_z_q;
  logic signed [31:0]      f_re_q;
  logic signed [31:0]      f_im_q;
  logic signed [fmtc_pkg::MODE_W-1:0] mx, my, mz;
  logic [fmtc_pkg::M2_W-1:0] sx, sy, sz;

  function automatic logic signed [fmtc_pkg::MODE_W-1:0] mode_of(
    input logic [9:0] c,
    input logic [fmtc_pkg::MESH_W-1:0] n
  );
    logic signed [fmtc_pkg::MODE_W-1:0] cs;
    logic signed [fmtc_pkg::MODE_W-1:0] ns;
    cs = $signed(fmtc_pkg::MODE_W'(c));
    ns = $signed(fmtc_pkg::MODE_W'(n));
    return (fmtc_pkg::MESH_W'(c) > (n >> 1)) ? cs - ns : cs;
  endfunction

  assign in_i.ready = !f_v_q || !full_i;
  assign push_o     = f_v_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (in_i.ready) begin
      f_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      f_op_q <= in_i.operation;
      f_ti_q <= in_i.table_index;
      f_lo_q <= in_i.lower_value;
      f_hi_q <= in_i.upper_value;
      f_x_q  <= in_i.x_coord;
      f_y_q  <= in_i.y_coord;
      f_z_q  <= in_i.z_coord;
      f_re_q <= in_i.real_part;
      f_im_q <= in_i.imag_part;
    end
  end

  always_comb begin
    mx = mode_of(f_x_q, cfg_i.mesh_n);
    my = mode_of(f_y_q, cfg_i.mesh_n);
    mz = mode_of(f_z_q, cfg_i.mesh_n);
    sx = mx * mx;
    sy = my * my;
    sz = mz * mz;
    data_o.op = fmtc_pkg::op_e'(f_op_q);
    data_o.ti = f_ti_q;
    data_o.lo = f_lo_q;
    data_o.hi = f_hi_q;
    data_o.m2 = sx + sy + sz;
    data_o.re = f_re_q;
    data_o.im = f_im_q;
  end

endmodule
`default_nettype wire

@@ sv/fmtc_back.sv @@
// Back: log2 by squaring, table lookup and interpolation, complex scaling.
`timescale 1ns / 1ps
`default_nettype none
module fmtc_back #(
  parameter int unsigned TABLE_DEPTH = fmtc_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire fmtc_pkg::cfg_t   cfg_i,
  input  wire fmtc_pkg::entry_t data_i,
  input  wire logic             empty_i,
  output logic                  pop_o,
  fmtc_out_if.source            out_o
);

  localparam int unsigned LAST = 26;
  localparam int unsigned MW = fmtc_pkg::MANT_W;
  localparam int unsigned FW = fmtc_pkg::FRAC_W;

  logic en;
  logic [LAST:0] v_q, v_d;
  logic out_valid_q;

  fmtc_pkg::entry_t ent0_q;
  fmtc_pkg::side_t  side_q [1:LAST];
  logic [MW-1:0]                 mant_q [1:17];
  logic [FW-1:0]                 frac_q [1:17];
  logic [fmtc_pkg::EXP_W-1:0]    exp_q  [1:17];
  logic [MW:0]                   sh_c   [2:17];

  logic [fmtc_pkg::EXP_W-1:0]    exp0;
  logic [MW-1:0]                 mant0;

  logic [fmtc_pkg::LOG_W+23:0]   prod_q;
  logic signed [33:0]            steps;
  logic [17:0]                   step_idx;
  logic [AW-1:0]                 raddr;
  logic [16:0]                   uk_d;
  logic                          flag_d;
  logic                          we;

  logic [16:0]                   uk_q [19:21];
  logic                          flag_q [19:LAST];

  logic [31:0] lo_a, lo_b, hi_a, hi_b;
  logic signed [17:0] w_lo, w_hi, w_a, w_b;
  logic signed [49:0] p0_q, p1_q, p2_q, p3_q;
  logic signed [49:0] s0, s1;
  logic signed [31:0] t1_q, t2_q;
  logic signed [49:0] q1_q, q2_q;
  logic signed [49:0] qs;
  logic signed [31:0] ratio_q;
  logic signed [56:0] rp_q;
  logic signed [33:0] corr_q;
  logic signed [65:0] pr_q, pi_q;
  logic signed [31:0] real_q, imag_q;
  logic               range_q;

  function automatic logic [MW:0] sq_step(input logic [MW-1:0] m);
    logic [2*MW-1:0] p;
    p = m * m;
    return p[2*MW-1:MW-1];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v[41:31] != {11{v[41]}}) begin
      r = v[41] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign en    = !out_valid_q || out_o.ready;
  assign pop_o = en && !empty_i;

  always_comb begin
    v_d = {v_q[LAST-1:0], !empty_i};
    v_d[19] = v_q[18] && (side_q[18].op == fmtc_pkg::OP_CELL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q         <= v_d;
      out_valid_q <= v_q[LAST];
    end
  end

  // normalize the squared magnitude
  always_comb begin
    exp0 = '0;
    for (int i = 0; i < fmtc_pkg::M2_W; i++) begin
      if (ent0_q.m2[i]) begin
        exp0 = fmtc_pkg::EXP_W'(i);
      end
    end
    mant0 = MW'(ent0_q.m2) << (fmtc_pkg::EXP_W'(MW - 1) - exp0);
  end

  always_comb begin
    for (int k = 2; k <= 17; k++) begin
      sh_c[k] = sq_step(mant_q[k-1]);
    end
  end

  // table position and clamp
  always_comb begin
    steps    = $signed({5'b0, prod_q[fmtc_pkg::LOG_W+23:16]}) + cfg_i.offset;
    step_idx = steps[33:16];
    if (steps[33]) begin
      raddr  = '0;
      uk_d   = '0;
      flag_d = 1'b1;
    end else if (32'(step_idx) > 32'(TABLE_DEPTH - 2)) begin
      raddr  = AW'(TABLE_DEPTH - 2);
      uk_d   = fmtc_pkg::ONE_Q16;
      flag_d = 1'b1;
    end else begin
      raddr  = AW'(step_idx);
      uk_d   = {1'b0, steps[15:0]};
      flag_d = 1'b0;
    end
    we = en && v_q[18] && (side_q[18].op == fmtc_pkg::OP_LOAD) &&
         (32'(side_q[18].ti) < 32'(TABLE_DEPTH));
  end

  fmtc_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_lower (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (AW'(side_q[18].ti)),
    .wdata_i   (side_q[18].lo),
    .re_i      (en),
    .raddr_a_i (raddr),
    .raddr_b_i (raddr + 1'b1),
    .rdata_a_o (lo_a),
    .rdata_b_o (lo_b)
  );

  fmtc_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_upper (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (AW'(side_q[18].ti)),
    .wdata_i   (side_q[18].hi),
    .re_i      (en),
    .raddr_a_i (raddr),
    .raddr_b_i (raddr + 1'b1),
    .rdata_a_o (hi_a),
    .rdata_b_o (hi_b)
  );

  always_comb begin
    w_hi = $signed({1'b0, cfg_i.blend});
    w_lo = $signed({1'b0, fmtc_pkg::ONE_Q16 - cfg_i.blend});
    w_b  = $signed({1'b0, uk_q[21]});
    w_a  = $signed({1'b0, fmtc_pkg::ONE_Q16 - uk_q[21]});
    s0   = p0_q + p1_q;
    s1   = p2_q + p3_q;
    qs   = q1_q + q2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ent0_q <= data_i;

      mant_q[1] <= mant0;
      exp_q[1]  <= exp0;
      frac_q[1] <= '0;
      side_q[1] <= '{op: ent0_q.op, dc: (ent0_q.m2 == '0), ti: ent0_q.ti,
                     lo: ent0_q.lo, hi: ent0_q.hi, re: ent0_q.re, im: ent0_q.im};
      for (int k = 2; k <= LAST; k++) begin
        side_q[k] <= side_q[k-1];
      end
      for (int k = 2; k <= 17; k++) begin
        frac_q[k] <= {frac_q[k-1][FW-2:0], sh_c[k][MW]};
        mant_q[k] <= sh_c[k][MW] ? sh_c[k][MW:1] : sh_c[k][MW-1:0];
        exp_q[k]  <= exp_q[k-1];
      end

      prod_q <= {exp_q[17], frac_q[17]} * cfg_i.scale;

      uk_q[19]   <= uk_d;
      flag_q[19] <= flag_d;
      for (int k = 20; k <= 21; k++) begin
        uk_q[k] <= uk_q[k-1];
      end
      for (int k = 20; k <= LAST; k++) begin
        flag_q[k] <= flag_q[k-1];
      end

      p0_q <= w_lo * $signed(lo_a);
      p1_q <= w_hi * $signed(hi_a);
      p2_q <= w_lo * $signed(lo_b);
      p3_q <= w_hi * $signed(hi_b);

      t1_q <= s0[47:16];
      t2_q <= s1[47:16];

      q1_q <= w_a * t1_q;
      q2_q <= w_b * t2_q;

      ratio_q <= qs[47:16];
      rp_q    <= ratio_q * $signed({1'b0, cfg_i.density});
      corr_q  <= $signed(fmtc_pkg::ONE_Q24) + $signed(rp_q[56:24]);
      pr_q    <= side_q[25].re * corr_q;
      pi_q    <= side_q[25].im * corr_q;

      if (side_q[LAST].dc) begin
        real_q  <= '0;
        imag_q  <= '0;
        range_q <= 1'b0;
      end else begin
        real_q  <= sat32(pr_q[65:24]);
        imag_q  <= sat32(pi_q[65:24]);
        range_q <= flag_q[LAST];
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.real_out   = real_q;
  assign out_o.imag_out   = imag_q;
  assign out_o.range_flag = range_q;

endmodule
`default_nettype wire

@@ sv/fourier_mesh_table_correction.sv @@
// Top level of the Fourier mesh table correction block.
// Usage:
//   Items arrive on in_i (valid/ready). An item with operation 0 loads one
//   entry pair of the ratio table; it produces no result. An item with
//   operation 1 is a mesh cell; it produces one transfer on out_o with the
//   corrected complex value and the range flag. Load all table entries a
//   cell may touch before sending cells.
//   Configuration registers are written through cfg_we_i, cfg_idx_i and
//   cfg_data_i, one per cycle. The user must write them only while no item
//   is in flight; the block itself does not enforce this. Throughput: one item
//   per cycle while out_o.ready is high. An item passes one front register,
//   the queue, the 16-step squaring log2 pipeline, the table RAM read and the multiply stages of the back.
//   When the receiver holds ready low the back stalls in place, the queue
//   absorbs up to four items, then in_i.ready drops.
//   Reset clears the pipeline, the queue and the registers to their reset
//   values; table contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module fourier_mesh_table_correction #(
  parameter int unsigned TABLE_DEPTH = fmtc_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned MESH_MAX    = fmtc_pkg::MESH_MAX_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  fmtc_in_if.sink                              in_i,
  fmtc_out_if.source                           out_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [fmtc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [fmtc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [10:0]        mesh_q;
  logic [23:0]        scale_q;
  logic signed [31:0] offset_q;
  logic [16:0]        blend_q;
  logic [23:0]        density_q;
  fmtc_pkg::cfg_t     cfg;

  fmtc_pkg::entry_t   push_data;
  fmtc_pkg::entry_t   pop_data;
  logic               push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mesh_q    <= fmtc_pkg::MESH_RESET;
      scale_q   <= fmtc_pkg::SCALE_RESET;
      offset_q  <= '0;
      blend_q   <= '0;
      density_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fmtc_pkg::CFG_MESH_SIZE:     mesh_q    <= cfg_data_i[10:0];
        fmtc_pkg::CFG_STEP_SCALE:    scale_q   <= cfg_data_i[23:0];
        fmtc_pkg::CFG_STEP_OFFSET:   offset_q  <= $signed(cfg_data_i);
        fmtc_pkg::CFG_ROW_BLEND:     blend_q   <= cfg_data_i[16:0];
        fmtc_pkg::CFG_DENSITY_RATIO: density_q <= cfg_data_i[23:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (mesh_q < 11'd2) begin
      cfg.mesh_n = fmtc_pkg::MESH_W'(2);
    end else if (fmtc_pkg::MESH_W'(mesh_q) > fmtc_pkg::MESH_W'(MESH_MAX)) begin
      cfg.mesh_n = fmtc_pkg::MESH_W'(MESH_MAX);
    end else begin
      cfg.mesh_n = fmtc_pkg::MESH_W'(mesh_q);
    end
    cfg.scale   = scale_q;
    cfg.offset  = offset_q;
    cfg.blend   = (blend_q > fmtc_pkg::ONE_Q16) ? fmtc_pkg::ONE_Q16 : blend_q;
    cfg.density = density_q;
  end

  fmtc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .push_o (push),
    .data_o (push_data),
    .full_i (full)
  );

  fmtc_fifo #(.DEPTH(fmtc_pkg::FIFO_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_data),
    .empty_o (empty)
  );

  fmtc_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .data_i  (pop_data),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire
